FILE: src/sgdlr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgdlr_pkg
// Shared types, constants and helpers for the fixed-point SGD trainer.
// ----------------------------------------------------------------------------
package sgdlr_pkg;

   localparam int WORD_BITS    = 64;
   localparam int HALF_BITS    = WORD_BITS / 2;
   localparam int MAX_FEATURES = 8;
   localparam int IDX_BITS     = $clog2(MAX_FEATURES);
   localparam int CNT_BITS     = $clog2(MAX_FEATURES + 1);
   localparam int FG_DEPTH     = 2 * MAX_FEATURES;
   localparam int SHIFT_BITS   = 6;
   localparam int BATCH_BITS   = 8;
   localparam int FCOUNT_BITS  = 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SHIFT_BITS-1:0]  FRAC_RESET   = 6'd18;
   localparam logic [SHIFT_BITS-1:0]  RATE_RESET   = 6'd7;
   localparam logic [BATCH_BITS-1:0]  BATCH_RESET  = 8'd2;
   localparam logic [FCOUNT_BITS-1:0] FCOUNT_RESET = 4'd5;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_FEATURE = 2'd1,
      KIND_LABEL   = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_FRAC   = 2'd0,
      REG_RATE   = 2'd1,
      REG_BATCH  = 2'd2,
      REG_FCOUNT = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDW,
      ST_FMS,
      ST_FMW,
      ST_LRES,
      ST_LRDF,
      ST_LRDG,
      ST_LMS,
      ST_LMW,
      ST_URD,
      ST_UT1,
      ST_UT2,
      ST_UWR,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [SHIFT_BITS-1:0]  frac_bits;
      logic [SHIFT_BITS-1:0]  rate_shift;
      logic [BATCH_BITS-1:0]  batch_size;
      logic [FCOUNT_BITS-1:0] feature_count;
   } cfg_type;

   // Divide by 2^s toward zero: shift the magnitude, restore the sign.
   function automatic logic [WORD_BITS-1:0] trunc_shift(
      input logic [WORD_BITS-1:0]  a,
      input logic [SHIFT_BITS-1:0] s
   );
      logic [WORD_BITS-1:0] mag;
      logic [WORD_BITS-1:0] sh;
      mag = a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a;
      sh  = mag >> s;
      return a[WORD_BITS-1] ? (~sh + WORD_BITS'(1)) : sh;
   endfunction

endpackage
`default_nettype wire

FILE: src/sgdlr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgdlr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgdlr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

FILE: src/sgdlr_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgdlr_mul
// Iterative low-word multiplier: three 32x32 partial products.
// ----------------------------------------------------------------------------
module sgdlr_mul (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [sgdlr_pkg::WORD_BITS-1:0]   a,
   input  wire logic [sgdlr_pkg::WORD_BITS-1:0]   b,
   output logic                                   done,
   output logic      [sgdlr_pkg::WORD_BITS-1:0]   prod
);

   localparam int W = sgdlr_pkg::WORD_BITS;
   localparam int H = sgdlr_pkg::HALF_BITS;

   logic         busy_ff, busy_in;
   logic [1:0]   cnt_ff;
   logic [W-1:0] a_ff, b_ff, part_ff, acc_ff;
   logic [H-1:0] op_x, op_y;
   logic [W-1:0] part_shifted;

   assign part_shifted = {part_ff[H-1:0], {H{1'b0}}};

   always_comb begin
      unique case (cnt_ff)
         2'd0: begin op_x = a_ff[H-1:0]; op_y = b_ff[H-1:0]; end
         2'd1: begin op_x = a_ff[H-1:0]; op_y = b_ff[W-1:H]; end
         2'd2: begin op_x = a_ff[W-1:H]; op_y = b_ff[H-1:0]; end
         2'd3: begin op_x = '0;          op_y = '0;          end
      endcase
   end

   assign done    = busy_ff && (cnt_ff == 2'd3);
   assign prod    = acc_ff + part_shifted;
   assign busy_in = start ? 1'b1 : (done ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         if (start) begin
            cnt_ff <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      part_ff <= W'(op_x) * W'(op_y);
      if (cnt_ff == 2'd1) begin
         acc_ff <= part_ff;
      end else if (cnt_ff == 2'd2) begin
         acc_ff <= acc_ff + part_shifted;
      end
   end

endmodule
`default_nettype wire

FILE: src/sgdlr_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgdlr_csr
// APB register file for the trainer configuration.
// ----------------------------------------------------------------------------
module sgdlr_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [sgdlr_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [sgdlr_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [sgdlr_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                       pready,
   output sgdlr_pkg::cfg_type                         cfg
);

   sgdlr_pkg::cfg_type cfg_ff, cfg_in;
   sgdlr_pkg::reg_type sel;
   logic               wr;

   assign sel    = sgdlr_pkg::reg_type'(paddr[3:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (sel)
         sgdlr_pkg::REG_FRAC: begin
            prdata = sgdlr_pkg::CSR_DATA_BITS'(cfg_ff.frac_bits);
            if (wr) cfg_in.frac_bits = pwdata[sgdlr_pkg::SHIFT_BITS-1:0];
         end
         sgdlr_pkg::REG_RATE: begin
            prdata = sgdlr_pkg::CSR_DATA_BITS'(cfg_ff.rate_shift);
            if (wr) cfg_in.rate_shift = pwdata[sgdlr_pkg::SHIFT_BITS-1:0];
         end
         sgdlr_pkg::REG_BATCH: begin
            prdata = sgdlr_pkg::CSR_DATA_BITS'(cfg_ff.batch_size);
            if (wr) cfg_in.batch_size = pwdata[sgdlr_pkg::BATCH_BITS-1:0];
         end
         sgdlr_pkg::REG_FCOUNT: begin
            prdata = sgdlr_pkg::CSR_DATA_BITS'(cfg_ff.feature_count);
            if (wr) cfg_in.feature_count = pwdata[sgdlr_pkg::FCOUNT_BITS-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frac_bits     <= sgdlr_pkg::FRAC_RESET;
         cfg_ff.rate_shift    <= sgdlr_pkg::RATE_RESET;
         cfg_ff.batch_size    <= sgdlr_pkg::BATCH_RESET;
         cfg_ff.feature_count <= sgdlr_pkg::FCOUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/fixed_point_sgd_linear_regression.sv
// Throughput: one transaction at a time, on a shared 32x32 multiplier and
//   one-read-port memories.
// A finished result waits in the output register while the next transaction runs.
// Reset (synchronous, active high) clears control state and the weight and
//   gradient valid bits, so weights and gradients read as zero; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_sgd_linear_regression
// Fixed-point minibatch SGD trainer for linear regression, memory based.
// ----------------------------------------------------------------------------
module fixed_point_sgd_linear_regression (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // input channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_kind,
   input  wire logic signed [sgdlr_pkg::WORD_BITS-1:0] req_value,
   input  wire logic [sgdlr_pkg::IDX_BITS-1:0]        req_weight_index,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [sgdlr_pkg::WORD_BITS-1:0]     rsp_result_value,
   output logic                                       rsp_batch_done,
   output logic                                       rsp_status,
   // configuration port
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [sgdlr_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [sgdlr_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [sgdlr_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                       pready
);

   localparam int W  = sgdlr_pkg::WORD_BITS;
   localparam int IB = sgdlr_pkg::IDX_BITS;
   localparam int CB = sgdlr_pkg::CNT_BITS;
   localparam int BB = sgdlr_pkg::BATCH_BITS;
   localparam int NF = sgdlr_pkg::MAX_FEATURES;

   sgdlr_pkg::cfg_type   cfg;
   sgdlr_pkg::state_type state_ff, state_in;
   sgdlr_pkg::kind_type  req_kind_t;

   // Transaction fields held for the whole sequence
   logic [W-1:0]  val_ff, val_in;
   logic [IB-1:0] idx_ff, idx_in;

   // Training state outside the memories
   logic [W-1:0]  dot_ff, dot_in;
   logic [CB-1:0] pos_ff, pos_in;
   logic [BB-1:0] samples_ff, samples_in;
   logic [NF-1:0] wvalid_ff, wvalid_in;
   logic [NF-1:0] gvalid_ff, gvalid_in;

   // Sequencer working registers
   logic [IB-1:0] loop_ff, loop_in;
   logic [W-1:0]  resid_ff, resid_in;
   logic [W-1:0]  opa_ff, opa_in;
   logic [W-1:0]  grad_ff, grad_in;
   logic [W-1:0]  wtmp_ff, wtmp_in;

   // Pending result and output register
   logic [W-1:0]  res_value_ff, res_value_in;
   logic          res_done_ff, res_done_in;
   logic          res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_value_ff, rsp_value_in;
   logic          rsp_done_ff, rsp_done_in;
   logic          rsp_status_ff, rsp_status_in;

   // Memory ports
   logic          w_we;
   logic [IB-1:0] w_waddr, w_raddr;
   logic [W-1:0]  w_wdata, w_rdata;
   logic          fg_we;
   logic [IB:0]   fg_waddr, fg_raddr;
   logic [W-1:0]  fg_wdata, fg_rdata;

   // Multiplier
   logic          mul_start, mul_done;
   logic [W-1:0]  mul_a, mul_b, mul_prod;

   // Effective feature count and batch size
   logic [CB-1:0] n_used;
   logic [BB-1:0] bsize;
   logic [BB-1:0] samples_inc;
   logic          last_feature;

   assign req_kind_t = sgdlr_pkg::kind_type'(req_kind);

   always_comb begin
      if (cfg.feature_count == '0) begin
         n_used = CB'(1);
      end else if (CB'(cfg.feature_count) > CB'(NF)) begin
         n_used = CB'(NF);
      end else begin
         n_used = CB'(cfg.feature_count);
      end
   end

   assign bsize        = (cfg.batch_size == '0) ? BB'(1) : cfg.batch_size;
   assign samples_inc  = samples_ff + BB'(1);
   assign last_feature = ({1'b0, loop_ff} + CB'(1)) == n_used;

   sgdlr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Weights, one word per feature slot
   sgdlr_ram #(.WIDTH(W), .DEPTH(NF)) u_wram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (w_wdata),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   // Sample features in the lower half, gradient sums in the upper half
   sgdlr_ram #(.WIDTH(W), .DEPTH(sgdlr_pkg::FG_DEPTH)) u_fgram (
      .clock (clock),
      .we    (fg_we),
      .waddr (fg_waddr),
      .wdata (fg_wdata),
      .raddr (fg_raddr),
      .rdata (fg_rdata)
   );

   sgdlr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign req_ready        = (state_ff == sgdlr_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_batch_done   = rsp_done_ff;
   assign rsp_status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      dot_in        = dot_ff;
      pos_in        = pos_ff;
      samples_in    = samples_ff;
      wvalid_in     = wvalid_ff;
      gvalid_in     = gvalid_ff;
      loop_in       = loop_ff;
      resid_in      = resid_ff;
      opa_in        = opa_ff;
      grad_in       = grad_ff;
      wtmp_in       = wtmp_ff;
      res_value_in  = res_value_ff;
      res_done_in   = res_done_ff;
      res_status_in = res_status_ff;
      // drop the output once the consumer takes it
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      w_we          = 1'b0;
      w_waddr       = idx_ff;
      w_wdata       = val_ff;
      w_raddr       = loop_ff;
      fg_we         = 1'b0;
      fg_waddr      = {1'b1, loop_ff};
      fg_wdata      = grad_ff;
      fg_raddr      = {1'b0, loop_ff};
      mul_start     = 1'b0;
      mul_a         = val_ff;
      mul_b         = resid_ff;

      unique case (state_ff)
         sgdlr_pkg::ST_IDLE: begin
            if (req_valid) begin
               val_in        = req_value;
               idx_in        = req_weight_index;
               res_value_in  = '0;
               res_done_in   = 1'b0;
               res_status_in = 1'b0;
               unique case (req_kind_t)
                  sgdlr_pkg::KIND_LOAD: begin
                     w_we                        = 1'b1;
                     w_waddr                     = req_weight_index;
                     w_wdata                     = req_value;
                     wvalid_in[req_weight_index] = 1'b1;
                     state_in                    = sgdlr_pkg::ST_FIN;
                  end
                  sgdlr_pkg::KIND_READ: begin
                     w_raddr  = req_weight_index;
                     state_in = sgdlr_pkg::ST_RDW;
                  end
                  sgdlr_pkg::KIND_FEATURE: begin
                     if (pos_ff >= n_used) begin
                        // extra feature: ignore, flag
                        res_status_in = 1'b1;
                        state_in      = sgdlr_pkg::ST_FIN;
                     end else begin
                        fg_we    = 1'b1;
                        fg_waddr = {1'b0, pos_ff[IB-1:0]};
                        fg_wdata = req_value;
                        w_raddr  = pos_ff[IB-1:0];
                        state_in = sgdlr_pkg::ST_FMS;
                     end
                  end
                  sgdlr_pkg::KIND_LABEL: begin
                     if (pos_ff < n_used) begin
                        // early label: ignore, keep the sample in progress
                        res_status_in = 1'b1;
                        state_in      = sgdlr_pkg::ST_FIN;
                     end else begin
                        state_in = sgdlr_pkg::ST_LRES;
                     end
                  end
               endcase
            end
         end

         sgdlr_pkg::ST_RDW: begin
            res_value_in = wvalid_ff[idx_ff] ? w_rdata : '0;
            state_in     = sgdlr_pkg::ST_FIN;
         end

         // Feature: dot += value * weight[pos]
         sgdlr_pkg::ST_FMS: begin
            mul_start = 1'b1;
            mul_a     = val_ff;
            mul_b     = wvalid_ff[pos_ff[IB-1:0]] ? w_rdata : '0;
            state_in  = sgdlr_pkg::ST_FMW;
         end

         sgdlr_pkg::ST_FMW: begin
            if (mul_done) begin
               dot_in   = dot_ff + mul_prod;
               pos_in   = pos_ff + CB'(1);
               state_in = sgdlr_pkg::ST_FIN;
            end
         end

         // Label: residual, then walk the features in use
         sgdlr_pkg::ST_LRES: begin
            resid_in     = sgdlr_pkg::trunc_shift(dot_ff, cfg.frac_bits) - val_ff;
            res_value_in = sgdlr_pkg::trunc_shift(dot_ff, cfg.frac_bits) - val_ff;
            loop_in      = '0;
            state_in     = sgdlr_pkg::ST_LRDF;
         end

         sgdlr_pkg::ST_LRDF: begin
            fg_raddr = {1'b0, loop_ff};
            state_in = sgdlr_pkg::ST_LRDG;
         end

         sgdlr_pkg::ST_LRDG: begin
            opa_in   = fg_rdata;
            fg_raddr = {1'b1, loop_ff};
            state_in = sgdlr_pkg::ST_LMS;
         end

         sgdlr_pkg::ST_LMS: begin
            grad_in   = gvalid_ff[loop_ff] ? fg_rdata : '0;
            mul_start = 1'b1;
            mul_a     = opa_ff;
            mul_b     = resid_ff;
            state_in  = sgdlr_pkg::ST_LMW;
         end

         sgdlr_pkg::ST_LMW: begin
            if (mul_done) begin
               fg_we              = 1'b1;
               fg_waddr           = {1'b1, loop_ff};
               fg_wdata           = grad_ff + mul_prod;
               gvalid_in[loop_ff] = 1'b1;
               if (last_feature) begin
                  dot_in = '0;
                  pos_in = '0;
                  if (samples_inc >= bsize || samples_inc == '0) begin
                     loop_in  = '0;
                     state_in = sgdlr_pkg::ST_URD;
                  end else begin
                     samples_in = samples_inc;
                     state_in   = sgdlr_pkg::ST_FIN;
                  end
               end else begin
                  loop_in  = loop_ff + IB'(1);
                  state_in = sgdlr_pkg::ST_LRDF;
               end
            end
         end

         // Batch close: weight -= trunc(trunc(grad, frac), rate) for every slot
         sgdlr_pkg::ST_URD: begin
            fg_raddr = {1'b1, loop_ff};
            w_raddr  = loop_ff;
            state_in = sgdlr_pkg::ST_UT1;
         end

         sgdlr_pkg::ST_UT1: begin
            grad_in  = sgdlr_pkg::trunc_shift(gvalid_ff[loop_ff] ? fg_rdata : '0,
                                              cfg.frac_bits);
            wtmp_in  = wvalid_ff[loop_ff] ? w_rdata : '0;
            state_in = sgdlr_pkg::ST_UT2;
         end

         sgdlr_pkg::ST_UT2: begin
            grad_in  = sgdlr_pkg::trunc_shift(grad_ff, cfg.rate_shift);
            state_in = sgdlr_pkg::ST_UWR;
         end

         sgdlr_pkg::ST_UWR: begin
            w_we               = 1'b1;
            w_waddr            = loop_ff;
            w_wdata            = wtmp_ff - grad_ff;
            wvalid_in[loop_ff] = 1'b1;
            if (loop_ff == IB'(NF - 1)) begin
               // clear all gradient sums at once
               gvalid_in   = '0;
               samples_in  = '0;
               res_done_in = 1'b1;
               state_in    = sgdlr_pkg::ST_FIN;
            end else begin
               loop_in  = loop_ff + IB'(1);
               state_in = sgdlr_pkg::ST_URD;
            end
         end

         // Hand the result to the output register when it is free
         sgdlr_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_done_in   = res_done_ff;
               rsp_status_in = res_status_ff;
               state_in      = sgdlr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sgdlr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgdlr_pkg::ST_IDLE;
         dot_ff       <= '0;
         pos_ff       <= '0;
         samples_ff   <= '0;
         wvalid_ff    <= '0;
         gvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dot_ff       <= dot_in;
         pos_ff       <= pos_in;
         samples_ff   <= samples_in;
         wvalid_ff    <= wvalid_in;
         gvalid_ff    <= gvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      loop_ff       <= loop_in;
      resid_ff      <= resid_in;
      opa_ff        <= opa_in;
      grad_ff       <= grad_in;
      wtmp_ff       <= wtmp_in;
      res_value_ff  <= res_value_in;
      res_done_ff   <= res_done_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
`default_nettype wire

FILE: src/sgdlr_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgdlr_check
// Port-level checks for the SGD trainer, bound to the top level.
// ----------------------------------------------------------------------------
module sgdlr_check (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [sgdlr_pkg::WORD_BITS-1:0] rsp_result_value,
   input wire logic                                   rsp_batch_done,
   input wire logic                                   rsp_status,
   input wire logic                                   pready
);

   // A stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_batch_done) && $stable(rsp_status))
      else $error("result changed while stalled");

   // A rejected transaction never closes a batch
   a_err_no_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_batch_done)
      else $error("sequence error with batch done");

   // A rejected transaction carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_result_value == '0)
      else $error("sequence error with nonzero value");

   // Leaving reset, no result is pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind fixed_point_sgd_linear_regression sgdlr_check u_sgdlr_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_batch_done   (rsp_batch_done),
   .rsp_status       (rsp_status),
   .pready           (pready)
);
`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point SGD trainer: drives weight loads,
// feature and label transactions and weight reads, predicts every response
// with a local copy of the trainer state, and checks the responses in order
// under random idling, result back-pressure and changing register settings.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WB            = sgdlr_pkg::WORD_BITS;
   localparam int ITEM_TARGET   = 1250;       // stop random stimulus near here
   localparam int CYCLE_LIMIT   = 1_000_000;  // hard stop for a hung run
   localparam int DRAIN_CYCLES  = 100;        // idle time after the final drain
   localparam int REPORT_LIMIT  = 10;

   localparam logic [WB-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;
   localparam logic [WB-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [WB-1:0] Q18_ONE   = 64'd1 << 18;

   // One expected response.
   typedef struct packed {
      logic [WB-1:0] value;
      logic          batch_done;
      logic          status;
   } train_outcome_type;

   // -------------------------------------------------------------------------
   // Clock, reset and the block's ports; every input starts at a known value
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid        = 1'b0;
   logic                                  req_ready;
   logic [1:0]                            req_kind         = sgdlr_pkg::KIND_READ;
   logic signed [WB-1:0]                  req_value        = '0;
   logic [sgdlr_pkg::IDX_BITS-1:0]        req_weight_index = '0;

   logic                                  rsp_valid;
   logic                                  rsp_ready        = 1'b0;
   logic signed [WB-1:0]                  rsp_result_value;
   logic                                  rsp_batch_done;
   logic                                  rsp_status;

   logic                                  psel             = 1'b0;
   logic                                  penable          = 1'b0;
   logic                                  pwrite           = 1'b0;
   logic [sgdlr_pkg::CSR_ADDR_BITS-1:0]   paddr            = '0;
   logic [sgdlr_pkg::CSR_DATA_BITS-1:0]   pwdata           = '0;
   logic [sgdlr_pkg::CSR_DATA_BITS-1:0]   prdata;
   logic                                  pready;

   always #5 clock = ~clock;

   fixed_point_sgd_linear_regression i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .req_weight_index (req_weight_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_batch_done   (rsp_batch_done),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // -------------------------------------------------------------------------
   // Trainer state as the bench predicts it
   // -------------------------------------------------------------------------
   logic [WB-1:0]   model_weight   [sgdlr_pkg::MAX_FEATURES];
   logic [WB-1:0]   model_feature  [sgdlr_pkg::MAX_FEATURES];
   logic [WB-1:0]   model_gradient [sgdlr_pkg::MAX_FEATURES];
   logic [WB-1:0]   model_dot;
   int unsigned     model_position;
   int unsigned     model_fill;

   logic [sgdlr_pkg::SHIFT_BITS-1:0]  cfg_frac   = sgdlr_pkg::FRAC_RESET;
   logic [sgdlr_pkg::SHIFT_BITS-1:0]  cfg_rate   = sgdlr_pkg::RATE_RESET;
   logic [sgdlr_pkg::BATCH_BITS-1:0]  cfg_batch  = sgdlr_pkg::BATCH_RESET;
   logic [sgdlr_pkg::FCOUNT_BITS-1:0] cfg_fcount = sgdlr_pkg::FCOUNT_RESET;

   // Responses still owed by the block, oldest first.
   train_outcome_type pending_outcomes [$];

   int  items_sent      = 0;
   int  results_checked = 0;
   int  batches_closed  = 0;
   int  csr_settings    = 0;
   int  mismatch_count  = 0;
   int  cycle_count     = 0;

   // Receiver controls: a hold-off count and a no-idle mode.
   int  hold_left       = 0;
   bit  calm_mode       = 1'b0;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Divide by 2^s rounding toward zero: shift the magnitude, then restore
   // the sign. The most negative word keeps its own bit pattern as magnitude.
   function automatic logic [WB-1:0] trunc_toward_zero(
      input logic [WB-1:0]                    a,
      input logic [sgdlr_pkg::SHIFT_BITS-1:0] s
   );
      logic [WB-1:0] mag;
      mag = a[WB-1] ? (64'd0 - a) : a;
      mag = mag >> s;
      return a[WB-1] ? (64'd0 - mag) : mag;
   endfunction

   // Feature count clamps to 1..MAX_FEATURES.
   function automatic int unsigned features_in_use();
      if (cfg_fcount == 0)
         return 1;
      if (cfg_fcount > sgdlr_pkg::MAX_FEATURES)
         return sgdlr_pkg::MAX_FEATURES;
      return 32'(cfg_fcount);
   endfunction

   // Advance the predicted state by one transaction and return its response.
   function automatic train_outcome_type train_step(
      input sgdlr_pkg::kind_type           k,
      input logic [WB-1:0]                 v,
      input logic [sgdlr_pkg::IDX_BITS-1:0] wi
   );
      train_outcome_type o;
      int unsigned       n;
      int unsigned       bsz;
      logic [WB-1:0]     resid;
      logic [WB-1:0]     delta;
      n   = features_in_use();
      bsz = (cfg_batch == 0) ? 1 : 32'(cfg_batch);
      o   = '0;
      case (k)
         sgdlr_pkg::KIND_LOAD: begin
            model_weight[wi] = v;
         end
         sgdlr_pkg::KIND_FEATURE: begin
            // drop a feature past the end of the sample
            if (model_position >= n) begin
               o.status = 1'b1;
            end else begin
               model_feature[model_position] = v;
               model_dot = model_dot + v * model_weight[model_position];
               model_position++;
            end
         end
         sgdlr_pkg::KIND_LABEL: begin
            // drop an early label, keep the partial sample
            if (model_position < n) begin
               o.status = 1'b1;
            end else begin
               resid = trunc_toward_zero(model_dot, cfg_frac) - v;
               for (int i = 0; i < n; i++)
                  model_gradient[i] = model_gradient[i] + model_feature[i] * resid;
               model_dot      = '0;
               model_position = 0;
               model_fill     = (model_fill + 1) & 8'hFF;
               if (model_fill >= bsz || model_fill == 0) begin
                  for (int i = 0; i < sgdlr_pkg::MAX_FEATURES; i++) begin
                     delta = trunc_toward_zero(trunc_toward_zero(model_gradient[i], cfg_frac),
                                               cfg_rate);
                     model_weight[i]   = model_weight[i] - delta;
                     model_gradient[i] = '0;
                  end
                  model_fill   = 0;
                  o.batch_done = 1'b1;
               end
               o.value = resid;
            end
         end
         default: begin
            o.value = model_weight[wi];
         end
      endcase
      return o;
   endfunction

   // -------------------------------------------------------------------------
   // Failure reporting: print the first few, count them all
   // -------------------------------------------------------------------------
   function automatic void note_failure(input string field, input logic [WB-1:0] want,
                                        input logic [WB-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] mismatch on %s at response %0d: expected %h, got %h",
                  $realtime, field, results_checked, want, got);
   endfunction

   // -------------------------------------------------------------------------
   // Response checker: compare each accepted response with the oldest
   // prediction, field by field
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      train_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            note_failure("unexpected response", '0, rsp_result_value);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_result_value !== want.value)
               note_failure("result_value", want.value, rsp_result_value);
            if (rsp_batch_done !== want.batch_done)
               note_failure("batch_done", 64'(want.batch_done), 64'(rsp_batch_done));
            if (rsp_status !== want.status)
               note_failure("status", 64'(want.status), 64'(rsp_status));
            if (want.batch_done)
               batches_closed++;
            results_checked++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: hold off while a hold count runs, else idle at random unless
   // calm mode is on
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else if (calm_mode) begin
         rsp_ready = 1'b1;
      end else begin
         rsp_ready = ($urandom_range(99) >= 16);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses owed",
                  cycle_count, pending_outcomes.size());
         $display("fixed_point_sgd_linear_regression test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Offer one transaction and hold it until accepted. Valid stays high on
   // return, so the caller must follow with another send or a drain.
   task automatic send_item(input sgdlr_pkg::kind_type k, input logic [WB-1:0] v,
                            input logic [sgdlr_pkg::IDX_BITS-1:0] wi);
      int gap;
      gap = 0;
      if (!calm_mode && $urandom_range(99) < 16)
         gap = $urandom_range(1, 2);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_kind         = k;
      req_value        = v;
      req_weight_index = wi;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(train_step(k, v, wi));
      items_sent++;
   endtask

   // Drop valid and wait until every owed response has come back; the block
   // is idle then, since each transaction yields exactly one response.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Write one register, mirror it in the prediction, and read it back.
   task automatic csr_write(input sgdlr_pkg::reg_type r,
                            input logic [sgdlr_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {r, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (r)
         sgdlr_pkg::REG_FRAC:  cfg_frac   = data[sgdlr_pkg::SHIFT_BITS-1:0];
         sgdlr_pkg::REG_RATE:  cfg_rate   = data[sgdlr_pkg::SHIFT_BITS-1:0];
         sgdlr_pkg::REG_BATCH: cfg_batch  = data[sgdlr_pkg::BATCH_BITS-1:0];
         default:              cfg_fcount = data[sgdlr_pkg::FCOUNT_BITS-1:0];
      endcase
      csr_settings++;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== data)
         note_failure("register readback", 64'(data), 64'(prdata));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Mostly modest signed values so training stays meaningful, with full
   // 64-bit noise and the extremes mixed in.
   function automatic logic [WB-1:0] pick_value();
      logic [WB-1:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       r = VALUE_MIN;
               1:       r = VALUE_MAX;
               2:       r = '0;
               default: r = '1;
            endcase
         end
         1, 2:    ;
         default: r = {{40{r[23]}}, r[23:0]};
      endcase
      return r;
   endfunction

   // Any weight index.
   function automatic logic [sgdlr_pkg::IDX_BITS-1:0] pick_index();
      return sgdlr_pkg::IDX_BITS'($urandom_range(sgdlr_pkg::MAX_FEATURES - 1));
   endfunction

   // One training phase: set all four registers with the block idle, then
   // stream samples. Most samples are well formed; the rest are weight loads,
   // weight reads, broken samples and samples with a stray extra feature.
   task automatic run_training_phase(input logic [sgdlr_pkg::SHIFT_BITS-1:0] frac,
                                     input logic [sgdlr_pkg::SHIFT_BITS-1:0] rate,
                                     input logic [sgdlr_pkg::BATCH_BITS-1:0] bsz,
                                     input logic [sgdlr_pkg::FCOUNT_BITS-1:0] fc,
                                     input int samples, input int hold);
      int unsigned n;
      int          roll;
      int          part;
      drain_results();
      csr_write(sgdlr_pkg::REG_FRAC, sgdlr_pkg::CSR_DATA_BITS'(frac));
      csr_write(sgdlr_pkg::REG_RATE, sgdlr_pkg::CSR_DATA_BITS'(rate));
      csr_write(sgdlr_pkg::REG_BATCH, sgdlr_pkg::CSR_DATA_BITS'(bsz));
      csr_write(sgdlr_pkg::REG_FCOUNT, sgdlr_pkg::CSR_DATA_BITS'(fc));
      n = features_in_use();
      hold_left = hold;
      repeat (samples) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            send_item(sgdlr_pkg::KIND_LOAD, pick_value(), pick_index());
         end else if (roll < 12) begin
            send_item(sgdlr_pkg::KIND_READ, pick_value(), pick_index());
         end else if (roll < 16) begin
            // partial sample, then a label that may come too early
            part = $urandom_range(0, n - 1);
            repeat (part) send_item(sgdlr_pkg::KIND_FEATURE, pick_value(), pick_index());
            send_item(sgdlr_pkg::KIND_LABEL, pick_value(), pick_index());
         end else begin
            while (model_position < n)
               send_item(sgdlr_pkg::KIND_FEATURE, pick_value(), pick_index());
            if (roll < 20)
               send_item(sgdlr_pkg::KIND_FEATURE, pick_value(), pick_index());
            send_item(sgdlr_pkg::KIND_LABEL, pick_value(), pick_index());
         end
      end
      drain_results();
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Hand-picked sequence on the reset settings (5 features, batch of 2,
   // Q18 format): reads of cleared weights, weight loads at the extremes,
   // an early label, an extra feature, and two samples closing one batch.
   task automatic test_directed_sequence();
      send_item(sgdlr_pkg::KIND_READ, '0, 3'd0);
      send_item(sgdlr_pkg::KIND_READ, '1, 3'd7);
      send_item(sgdlr_pkg::KIND_LABEL, Q18_ONE, 3'd0);
      send_item(sgdlr_pkg::KIND_LOAD, VALUE_MIN, 3'd7);
      send_item(sgdlr_pkg::KIND_READ, '0, 3'd7);
      send_item(sgdlr_pkg::KIND_LOAD, VALUE_MAX, 3'd0);
      send_item(sgdlr_pkg::KIND_LOAD, Q18_ONE, 3'd0);
      send_item(sgdlr_pkg::KIND_LOAD, 64'd0 - (Q18_ONE >> 1), 3'd1);
      send_item(sgdlr_pkg::KIND_FEATURE, VALUE_MAX, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, VALUE_MIN, 3'd7);
      send_item(sgdlr_pkg::KIND_FEATURE, '0, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, '1, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, Q18_ONE, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, Q18_ONE, 3'd0);
      send_item(sgdlr_pkg::KIND_LABEL, VALUE_MIN, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, Q18_ONE, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, Q18_ONE << 1, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, 64'd0 - 64'd3 * Q18_ONE, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, '0, 3'd0);
      send_item(sgdlr_pkg::KIND_FEATURE, 64'd5, 3'd0);
      send_item(sgdlr_pkg::KIND_LABEL, Q18_ONE, 3'd0);
      send_item(sgdlr_pkg::KIND_READ, '0, 3'd0);
      send_item(sgdlr_pkg::KIND_READ, '0, 3'd1);
      drain_results();
   endtask

   // No truncation at all, then the widest shifts with a zero feature count
   // and a zero batch size, both of which act as one.
   task automatic test_shift_extremes();
      run_training_phase(6'd0, 6'd0, 8'd1, 4'd1, 50, 0);
      run_training_phase(6'd63, 6'd63, 8'd0, 4'd0, 30, 0);
      run_training_phase(6'd62, 6'd62, 8'd2, 4'd3, 15, 0);
   endtask

   // Full eight-feature samples under the largest batch, then shrink the
   // batch below the samples gathered so the next label closes it; a feature
   // count above the maximum acts as the maximum.
   task automatic test_batch_shrink();
      run_training_phase(6'd12, 6'd3, 8'd255, 4'd8, 30, 0);
      run_training_phase(6'd12, 6'd3, 8'd4, 4'd15, 12, 0);
   endtask

   // A stretch with no idling on either side.
   task automatic test_steady_stream();
      calm_mode = 1'b1;
      run_training_phase(6'd16, 6'd5, 8'd3, 4'd4, 40, 0);
      calm_mode = 1'b0;
   endtask

   // Hold off the receiver for a long stretch while the sender keeps going,
   // so the block fills and stalls its input.
   task automatic test_result_backpressure();
      run_training_phase(6'd18, 6'd7, 8'd2, 4'd5, 25, 400);
   endtask

   // Random settings, mostly in the useful range, until the item count is met.
   task automatic test_random_training();
      logic [sgdlr_pkg::SHIFT_BITS-1:0]  frac;
      logic [sgdlr_pkg::SHIFT_BITS-1:0]  rate;
      logic [sgdlr_pkg::BATCH_BITS-1:0]  bsz;
      logic [sgdlr_pkg::FCOUNT_BITS-1:0] fc;
      while (items_sent < ITEM_TARGET) begin
         frac = sgdlr_pkg::SHIFT_BITS'(($urandom_range(3) == 0) ?
                   $urandom_range(0, 63) : $urandom_range(8, 24));
         rate = sgdlr_pkg::SHIFT_BITS'(($urandom_range(3) == 0) ?
                   $urandom_range(0, 63) : $urandom_range(0, 8));
         bsz  = sgdlr_pkg::BATCH_BITS'(($urandom_range(7) == 0) ?
                   $urandom_range(0, 255) : $urandom_range(1, 6));
         fc   = sgdlr_pkg::FCOUNT_BITS'(($urandom_range(5) == 0) ?
                   $urandom_range(0, 15) : $urandom_range(1, 5));
         run_training_phase(frac, rate, bsz, fc, $urandom_range(15, 40), 0);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < sgdlr_pkg::MAX_FEATURES; i++) begin
         model_weight[i]   = '0;
         model_feature[i]  = '0;
         model_gradient[i] = '0;
      end
      model_dot      = '0;
      model_position = 0;
      model_fill     = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_sequence();
      test_shift_extremes();
      test_batch_shrink();
      test_steady_stream();
      test_result_backpressure();
      test_random_training();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d transactions and %0d checked responses", items_sent,
               results_checked);
      $display("with %0d weight updates across %0d register writes", batches_closed,
               csr_settings);
      if (mismatch_count == 0) begin
         $display("fixed_point_sgd_linear_regression test passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("fixed_point_sgd_linear_regression test failed");
      end
      $finish;
   end

endmodule

FILE: files.f
src/sgdlr_pkg.sv
src/sgdlr_ram.sv
src/sgdlr_mul.sv
src/sgdlr_csr.sv
src/fixed_point_sgd_linear_regression.sv
src/sgdlr_check.sv
verif/tb_top.sv
